@@ design/ejms_pkg.sv @@
// ----------------------------------------------------------------------------
// ejms_pkg
// Types, codes and reset values of the event jet and MET selector.
// ----------------------------------------------------------------------------
package ejms_pkg;

  localparam int ANGLE_BITS_DEF = 12;

  localparam int PT_W    = 16;
  localparam int ETA_W   = 12;
  localparam int PHI_W   = 12;
  localparam int ETAC_W  = 11;
  localparam int CNT_W   = 8;
  localparam int OANG_W  = 12;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 112;

  typedef enum logic [1:0] {
    ACT_HEADER   = 2'd0,
    ACT_ELECTRON = 2'd1,
    ACT_MUON     = 2'd2,
    ACT_JET      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAGE_ALL     = 2'd0,
    STAGE_NO_LEP  = 2'd1,
    STAGE_MIN_ANG = 2'd2,
    STAGE_MET     = 2'd3
  } stage_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_LEPTON_PT_MIN  = 3'd0,
    REG_LEPTON_ETA_MAX = 3'd1,
    REG_JET_PT_MIN     = 3'd2,
    REG_JET_ETA_MAX    = 3'd3,
    REG_BJET_ETA_MAX   = 3'd4,
    REG_DPHI_JET_LIMIT = 3'd5,
    REG_MIN_ANGLE_CUT  = 3'd6,
    REG_MET_CUT        = 3'd7
  } cfg_index_t;

  localparam logic [PT_W-1:0]   LEPTON_PT_MIN_RST  = 16'd40;
  localparam logic [ETAC_W-1:0] LEPTON_ETA_MAX_RST = 11'd640;
  localparam logic [PT_W-1:0]   JET_PT_MIN_RST     = 16'd120;
  localparam logic [ETAC_W-1:0] JET_ETA_MAX_RST    = 11'd1024;
  localparam logic [ETAC_W-1:0] BJET_ETA_MAX_RST   = 11'd614;
  localparam logic [CNT_W-1:0]  DPHI_JET_LIMIT_RST = 8'd6;
  localparam logic [OANG_W-1:0] MIN_ANGLE_CUT_RST  = 12'd652;
  localparam logic [PT_W-1:0]   MET_CUT_RST        = 16'd800;

  localparam logic [OANG_W-1:0] NO_ANGLE = 12'hFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;

endpackage

@@ design/event_jet_met_selector.sv @@
// ----------------------------------------------------------------------------
// event_jet_met_selector
// Counts leptons, jets and b-jets of each event and emits one summary item.
// ----------------------------------------------------------------------------
// The slave stream carries objects: a header item with MET and its angle opens
// an event, electron, muon and jet items follow, and the item with tlast set
// closes it. The object kind travels in s_tuser. For every closing item one
// summary item leaves on the master stream; other items produce nothing.
// Cuts are to be set through the write port only while the block is idle;
// the block itself does not enforce it. An accepted item is held in the
// input register; when it advances, it updates the event accumulators and,
// when it closes the event, loads the result register that drives m_tvalid.
// One item is taken every cycle unless a closing item waits for the receiver;
// the rate is set by the single update of the accumulators per cycle.
// When the receiver stalls, items without tlast still flow; a closing item
// waits in the input register until the held summary is taken.
// Reset restores the default cuts, clears MET and the counts and leading jets,
// sets both angle accumulators to NO_ANGLE and empties both registers.
// ----------------------------------------------------------------------------
module event_jet_met_selector
  import ejms_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // tdata: pt[15:0], eta[27:16], phi[39:28], btag[40], zero fill
  input  logic [IN_DW-1:0]     s_tdata,
  // tuser: action[1:0]
  input  logic [1:0]           s_tuser,
  input  logic                 s_tlast,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // tdata: lepton_count[7:0], jet_count[15:8], bjet_count[23:16],
  // min_angle[35:24], lead_jet_pt[51:36], lead_jet_eta[63:52],
  // lead_bjet_pt[79:64], lead_bjet_eta[91:80], bjet_dphi[103:92],
  // stage_passed[105:104], zero fill
  output logic [OUT_DW-1:0]    m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_wen,
  input  logic [CIDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW  = (ANGLE_BITS > OANG_W) ? ANGLE_BITS : OANG_W;
  localparam int EXT = ANGLE_BITS + PHI_W;
  localparam logic [AW-1:0] NO_ANG_W = AW'(NO_ANGLE);

  logic [PT_W-1:0]   lepton_pt_min;
  logic [ETAC_W-1:0] lepton_eta_max;
  logic [PT_W-1:0]   jet_pt_min;
  logic [ETAC_W-1:0] jet_eta_max;
  logic [ETAC_W-1:0] bjet_eta_max;
  logic [CNT_W-1:0]  dphi_jet_limit;
  logic [OANG_W-1:0] min_angle_cut;
  logic [PT_W-1:0]   met_cut;

  logic              in_valid;
  action_t           in_action;
  logic [PT_W-1:0]   in_pt;
  logic [ETA_W-1:0]  in_eta;
  logic [PHI_W-1:0]  in_phi;
  logic              in_btag;
  logic              in_last;
  logic              advance;

  logic [PT_W-1:0]   met_value, met_value_next;
  logic [PHI_W-1:0]  met_angle, met_angle_next;
  logic [CNT_W-1:0]  lepton_tally, lepton_tally_next;
  logic [CNT_W-1:0]  jet_tally, jet_tally_next;
  logic [CNT_W-1:0]  bjet_tally, bjet_tally_next;
  logic [AW-1:0]     smallest_angle, smallest_angle_next;
  logic [PT_W-1:0]   first_jet_pt, first_jet_pt_next;
  logic [ETA_W-1:0]  first_jet_eta, first_jet_eta_next;
  logic [PT_W-1:0]   first_bjet_pt, first_bjet_pt_next;
  logic [ETA_W-1:0]  first_bjet_eta, first_bjet_eta_next;
  logic [AW-1:0]     recent_bjet_angle, recent_bjet_angle_next;

  logic [ETA_W-1:0]      abs_eta;
  logic                  lep_ok, jet_ok, bjet_ok;
  logic [EXT-1:0]        phi_diff;
  logic [ANGLE_BITS-1:0] d_raw, d_mag;
  logic [AW-1:0]         angle;
  stage_t                stage;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      lepton_pt_min  <= LEPTON_PT_MIN_RST;
      lepton_eta_max <= LEPTON_ETA_MAX_RST;
      jet_pt_min     <= JET_PT_MIN_RST;
      jet_eta_max    <= JET_ETA_MAX_RST;
      bjet_eta_max   <= BJET_ETA_MAX_RST;
      dphi_jet_limit <= DPHI_JET_LIMIT_RST;
      min_angle_cut  <= MIN_ANGLE_CUT_RST;
      met_cut        <= MET_CUT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index_t'(cfg_index))
        REG_LEPTON_PT_MIN:  lepton_pt_min  <= cfg_data;
        REG_LEPTON_ETA_MAX: lepton_eta_max <= cfg_data[ETAC_W-1:0];
        REG_JET_PT_MIN:     jet_pt_min     <= cfg_data;
        REG_JET_ETA_MAX:    jet_eta_max    <= cfg_data[ETAC_W-1:0];
        REG_BJET_ETA_MAX:   bjet_eta_max   <= cfg_data[ETAC_W-1:0];
        REG_DPHI_JET_LIMIT: dphi_jet_limit <= cfg_data[CNT_W-1:0];
        REG_MIN_ANGLE_CUT:  min_angle_cut  <= cfg_data[OANG_W-1:0];
        REG_MET_CUT:        met_cut        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= action_t'(s_tuser);
      in_pt     <= s_tdata[15:0];
      in_eta    <= s_tdata[27:16];
      in_phi    <= s_tdata[39:28];
      in_btag   <= s_tdata[40];
      in_last   <= s_tlast;
    end
  end

  assign abs_eta = in_eta[ETA_W-1] ? (~in_eta + 12'd1) : in_eta;
  assign lep_ok  = (in_pt > lepton_pt_min) && (abs_eta < ETA_W'(lepton_eta_max));
  assign jet_ok  = (abs_eta < ETA_W'(jet_eta_max)) && (in_pt > jet_pt_min);
  assign bjet_ok = jet_ok && (abs_eta < ETA_W'(bjet_eta_max)) && in_btag;

  assign phi_diff = {{ANGLE_BITS{in_phi[PHI_W-1]}}, in_phi}
                  - {{ANGLE_BITS{met_angle[PHI_W-1]}}, met_angle};
  assign d_raw    = phi_diff[ANGLE_BITS-1:0];
  assign d_mag    = (!d_raw[ANGLE_BITS-1] || (d_raw[ANGLE_BITS-2:0] == '0))
                  ? d_raw : (~d_raw + 1'b1);
  assign angle    = AW'(d_mag);

  always_comb begin
    met_value_next         = met_value;
    met_angle_next         = met_angle;
    lepton_tally_next      = lepton_tally;
    jet_tally_next         = jet_tally;
    bjet_tally_next        = bjet_tally;
    smallest_angle_next    = smallest_angle;
    first_jet_pt_next      = first_jet_pt;
    first_jet_eta_next     = first_jet_eta;
    first_bjet_pt_next     = first_bjet_pt;
    first_bjet_eta_next    = first_bjet_eta;
    recent_bjet_angle_next = recent_bjet_angle;
    unique case (in_action)
      ACT_HEADER: begin
        met_value_next         = in_pt;
        met_angle_next         = in_phi;
        lepton_tally_next      = '0;
        jet_tally_next         = '0;
        bjet_tally_next        = '0;
        smallest_angle_next    = NO_ANG_W;
        first_jet_pt_next      = '0;
        first_jet_eta_next     = '0;
        first_bjet_pt_next     = '0;
        first_bjet_eta_next    = '0;
        recent_bjet_angle_next = NO_ANG_W;
      end
      ACT_ELECTRON, ACT_MUON: begin
        if (lep_ok && (lepton_tally != CNT_MAX)) begin
          lepton_tally_next = lepton_tally + 1'b1;
        end
      end
      ACT_JET: begin
        if (jet_ok) begin
          if ((jet_tally < dphi_jet_limit) && (angle < smallest_angle)) begin
            smallest_angle_next = angle;
          end
          if (jet_tally == '0) begin
            first_jet_pt_next  = in_pt;
            first_jet_eta_next = in_eta;
          end
          if (jet_tally != CNT_MAX) begin
            jet_tally_next = jet_tally + 1'b1;
          end
          if (bjet_ok) begin
            if (bjet_tally == '0) begin
              first_bjet_pt_next  = in_pt;
              first_bjet_eta_next = in_eta;
            end
            if (bjet_tally != CNT_MAX) begin
              bjet_tally_next = bjet_tally + 1'b1;
            end
            recent_bjet_angle_next = angle;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (lepton_tally_next != '0) begin
      stage = STAGE_ALL;
    end else if (smallest_angle_next <= AW'(min_angle_cut)) begin
      stage = STAGE_NO_LEP;
    end else if (met_value_next <= met_cut) begin
      stage = STAGE_MIN_ANG;
    end else begin
      stage = STAGE_MET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      met_value         <= '0;
      met_angle         <= '0;
      lepton_tally      <= '0;
      jet_tally         <= '0;
      bjet_tally        <= '0;
      smallest_angle    <= NO_ANG_W;
      first_jet_pt      <= '0;
      first_jet_eta     <= '0;
      first_bjet_pt     <= '0;
      first_bjet_eta    <= '0;
      recent_bjet_angle <= NO_ANG_W;
    end else if (advance) begin
      met_value <= met_value_next;
      met_angle <= met_angle_next;
      if (in_last) begin
        lepton_tally      <= '0;
        jet_tally         <= '0;
        bjet_tally        <= '0;
        smallest_angle    <= NO_ANG_W;
        first_jet_pt      <= '0;
        first_jet_eta     <= '0;
        first_bjet_pt     <= '0;
        first_bjet_eta    <= '0;
        recent_bjet_angle <= NO_ANG_W;
      end else begin
        lepton_tally      <= lepton_tally_next;
        jet_tally         <= jet_tally_next;
        bjet_tally        <= bjet_tally_next;
        smallest_angle    <= smallest_angle_next;
        first_jet_pt      <= first_jet_pt_next;
        first_jet_eta     <= first_jet_eta_next;
        first_bjet_pt     <= first_bjet_pt_next;
        first_bjet_eta    <= first_bjet_eta_next;
        recent_bjet_angle <= recent_bjet_angle_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {6'd0,
                  stage,
                  recent_bjet_angle_next[OANG_W-1:0],
                  first_bjet_eta_next,
                  first_bjet_pt_next,
                  first_jet_eta_next,
                  first_jet_pt_next,
                  smallest_angle_next[OANG_W-1:0],
                  bjet_tally_next,
                  jet_tally_next,
                  lepton_tally_next};
    end
  end

endmodule
